// ----- rtl/assert_macros.svh -----
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/elgt_pkg.sv -----
package elgt_pkg;

  localparam int unsigned VOCAB_DEF = 1024;
  localparam int unsigned DIM_DEF   = 16;

  localparam int OP_W   = 3;
  localparam int TOK_W  = 16;
  localparam int COL_W  = 6;
  localparam int VAL_W  = 16;
  localparam int RES_W  = 24;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 11;
  localparam int CIDX_W = 2;

  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PAD    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FROZEN = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_ENTRIES = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PADDING = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FROZEN  = 2'd2;

  localparam logic [CFG_W-1:0] ENTRIES_RST = 11'd1024;
  localparam logic [CFG_W-1:0] PADDING_RST = 11'h7FF;

  localparam logic signed [RES_W-1:0] GRAD_MAX = 24'sh7FFFFF;
  localparam logic signed [RES_W-1:0] GRAD_MIN = 24'sh800000;

  function automatic logic signed [RES_W-1:0] grad_sat(input logic signed [RES_W:0] s);
    logic signed [RES_W-1:0] r;
    if (s > RES_W'(GRAD_MAX) && !s[RES_W]) begin
      r = GRAD_MAX;
    end else if (s[RES_W] && !s[RES_W-1]) begin
      r = GRAD_MIN;
    end else if (!s[RES_W] && s[RES_W-1]) begin
      r = GRAD_MAX;
    end else begin
      r = s[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/embedding_lookup_grad_table_core.sv -----
// Embedding table with gradient accumulator (gather / scatter-add).
// Input channel in_*: one command beat (operation, token_id, column, value),
// taken when in_valid is high and in_stall is low. Result channel out_*: beats
// of (result_value, result_column, last, status), taken when out_valid is high
// and out_stall is low. cfg_*: register writes, cfg_ready is always high.
// Per-element commands (write weight, add/read/clear gradient) give one beat,
// registered from the ELEM state once the output register can take it; the
// next command is taken only after the return to IDLE, the read-modify-write
// going through the gradient memory's registered read port.
// A lookup streams DIM beats, one per cycle from the weight memory while the
// result side does not stall, the last flagged. Codes 5..7 give no beat.
// After reset the gradient memory is swept to zero, one entry per cycle, over
// all 2**(row bits + column bits) entries (16384 by default); in_stall is high
// meanwhile. A stall on the result side freezes the sequencer; the beat in the
// output register holds until taken.
`include "assert_macros.svh"

module embedding_lookup_grad_table_core #(
  parameter int VOCAB = elgt_pkg::VOCAB_DEF,
  parameter int DIM   = elgt_pkg::DIM_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [elgt_pkg::OP_W-1:0]            in_operation,
  input  logic signed [elgt_pkg::TOK_W-1:0]    in_token_id,
  input  logic [elgt_pkg::COL_W-1:0]           in_column,
  input  logic signed [elgt_pkg::VAL_W-1:0]    in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [elgt_pkg::RES_W-1:0]    out_result_value,
  output logic [elgt_pkg::COL_W-1:0]           out_result_column,
  output logic                                 out_last,
  output logic [elgt_pkg::STAT_W-1:0]          out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [elgt_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [elgt_pkg::CFG_W-1:0]           cfg_data
);

  localparam int RW    = $clog2(VOCAB);
  localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW    = RW + CW;
  localparam int CNT_W = $clog2(DIM + 1);
  localparam int TU_W  = elgt_pkg::TOK_W + 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_ELEM  = 2'd2;
  localparam logic [1:0] S_LOOK  = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic                                pend_r, pend_nxt;
  logic [AW-1:0]                       clr_r, clr_nxt;
  logic [CW-1:0]                       pend_col_r;

  logic [elgt_pkg::CFG_W-1:0]          entries_r;
  logic [elgt_pkg::CFG_W-1:0]          padding_r;
  logic                                frozen_r;

  logic [elgt_pkg::OP_W-1:0]           op_r;
  logic [RW-1:0]                       row_r;
  logic [elgt_pkg::COL_W-1:0]          col_r;
  logic signed [elgt_pkg::VAL_W-1:0]   val_r;
  logic                                tv_r, cv_r, pad_r;

  logic                                out_valid_r;
  logic signed [elgt_pkg::RES_W-1:0]   out_value_r;
  logic [elgt_pkg::COL_W-1:0]          out_col_r;
  logic                                out_last_r;
  logic [elgt_pkg::STAT_W-1:0]         out_status_r;

  logic                                in_acc;
  logic [TU_W-1:0]                     tok_u;
  logic                                tv_in, cv_in, pad_in;
  logic [AW-1:0]                       in_addr, elem_addr;

  logic                                out_can_load, out_load;
  logic                                elem_go, consume, issue, look_last;

  logic                                g_we;
  logic [AW-1:0]                       g_waddr;
  logic [elgt_pkg::RES_W-1:0]          g_wdata;
  logic [elgt_pkg::RES_W-1:0]          g_q;
  logic                                w_we, w_re;
  logic [elgt_pkg::VAL_W-1:0]          w_wdata;
  logic [elgt_pkg::VAL_W-1:0]          w_q;

  logic signed [elgt_pkg::RES_W:0]     grad_sum;
  logic signed [elgt_pkg::RES_W-1:0]   grad_new;
  logic signed [elgt_pkg::RES_W-1:0]   ld_value;
  logic [elgt_pkg::COL_W-1:0]          ld_col;
  logic                                ld_last;
  logic [elgt_pkg::STAT_W-1:0]         ld_status;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  assign tok_u  = {2'b00, in_token_id[elgt_pkg::TOK_W-2:0]};
  assign tv_in  = !in_token_id[elgt_pkg::TOK_W-1]
                  && (tok_u < TU_W'(entries_r))
                  && (tok_u < TU_W'(VOCAB));
  assign cv_in  = ({1'b0, in_column} < (elgt_pkg::COL_W + 1)'(DIM));
  assign pad_in = tv_in && !padding_r[elgt_pkg::CFG_W-1]
                  && (tok_u == TU_W'(padding_r[elgt_pkg::CFG_W-2:0]));
  assign in_addr   = {in_token_id[RW-1:0], in_column[CW-1:0]};
  assign elem_addr = {row_r, col_r[CW-1:0]};

  assign out_can_load = !out_valid_r || !out_stall;
  assign elem_go      = (state_r == S_ELEM) && out_can_load;
  assign consume      = (state_r == S_LOOK) && pend_r && out_can_load;
  assign issue        = (state_r == S_LOOK) && (cnt_r < CNT_W'(DIM)) && (!pend_r || consume);
  assign look_last    = (pend_col_r == CW'(DIM - 1));
  assign out_load     = elem_go || consume;

  assign grad_sum = (elgt_pkg::RES_W + 1)'($signed(g_q)) + (elgt_pkg::RES_W + 1)'(val_r);
  assign grad_new = elgt_pkg::grad_sat(grad_sum);

  // gradient memory write port: reset sweep or element writeback
  always_comb begin
    g_we    = 1'b0;
    g_waddr = elem_addr;
    g_wdata = '0;
    if (state_r == S_CLEAR) begin
      g_we    = 1'b1;
      g_waddr = clr_r;
    end else if (elem_go && tv_r && cv_r) begin
      if (op_r == elgt_pkg::OP_ADD) begin
        g_we    = !frozen_r && !pad_r;
        g_wdata = grad_new;
      end else if (op_r == elgt_pkg::OP_CLEAR) begin
        g_we    = 1'b1;
      end
    end
  end

  assign w_we    = elem_go && (op_r == elgt_pkg::OP_WRITE) && tv_r && cv_r;
  assign w_wdata = pad_r ? '0 : val_r;
  assign w_re    = issue;

  elgt_ram #(.DW(elgt_pkg::RES_W), .AW(AW)) u_grad_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (g_q)
  );

  elgt_ram #(.DW(elgt_pkg::VAL_W), .AW(AW)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (elem_addr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr ({row_r, cnt_r[CW-1:0]}),
    .rdata (w_q)
  );

  // result beat selection
  always_comb begin
    ld_value  = '0;
    ld_col    = col_r;
    ld_last   = 1'b1;
    ld_status = elgt_pkg::STAT_OK;
    if (state_r == S_LOOK) begin
      ld_col  = elgt_pkg::COL_W'(pend_col_r);
      ld_last = look_last;
      if (!tv_r) begin
        ld_status = elgt_pkg::STAT_RANGE;
      end else if (pad_r) begin
        ld_status = elgt_pkg::STAT_PAD;
      end else begin
        ld_value  = elgt_pkg::RES_W'($signed(w_q));
      end
    end else begin
      case (op_r)
        elgt_pkg::OP_WRITE, elgt_pkg::OP_CLEAR: begin
          if (!tv_r || !cv_r) begin
            ld_status = elgt_pkg::STAT_RANGE;
          end else if (pad_r && op_r == elgt_pkg::OP_WRITE) begin
            ld_status = elgt_pkg::STAT_PAD;
          end
        end
        elgt_pkg::OP_ADD: begin
          if (frozen_r) begin
            ld_status = elgt_pkg::STAT_FROZEN;
          end else if (!tv_r || !cv_r) begin
            ld_status = elgt_pkg::STAT_RANGE;
          end else if (pad_r) begin
            ld_status = elgt_pkg::STAT_PAD;
          end else begin
            ld_value  = grad_new;
          end
        end
        elgt_pkg::OP_READ: begin
          if (!tv_r || !cv_r) begin
            ld_status = elgt_pkg::STAT_RANGE;
          end else begin
            ld_value  = $signed(g_q);
          end
        end
        default: begin
          ld_status = elgt_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    clr_nxt   = clr_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_operation)
            elgt_pkg::OP_LOOKUP: begin
              state_nxt = S_LOOK;
              cnt_nxt   = '0;
              pend_nxt  = 1'b0;
            end
            elgt_pkg::OP_WRITE, elgt_pkg::OP_ADD, elgt_pkg::OP_READ,
            elgt_pkg::OP_CLEAR: begin
              state_nxt = S_ELEM;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ELEM: begin
        if (out_can_load) begin
          state_nxt = S_IDLE;
        end
      end
      S_LOOK: begin
        if (issue) begin
          cnt_nxt  = cnt_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else if (consume) begin
          pend_nxt = 1'b0;
        end
        if (consume && look_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      entries_r   <= elgt_pkg::ENTRIES_RST;
      padding_r   <= elgt_pkg::PADDING_RST;
      frozen_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      clr_r   <= clr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          elgt_pkg::CFG_ENTRIES: entries_r <= cfg_data;
          elgt_pkg::CFG_PADDING: padding_r <= cfg_data;
          elgt_pkg::CFG_FROZEN:  frozen_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_operation;
      row_r <= in_token_id[RW-1:0];
      col_r <= in_column;
      val_r <= in_value;
      tv_r  <= tv_in;
      cv_r  <= cv_in;
      pad_r <= pad_in;
    end
    if (issue) begin
      pend_col_r <= cnt_r[CW-1:0];
    end
    if (out_load) begin
      out_value_r  <= ld_value;
      out_col_r    <= ld_col;
      out_last_r   <= ld_last;
      out_status_r <= ld_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_result_column = out_col_r;
  assign out_last          = out_last_r;
  assign out_status        = out_status_r;

  `ASSERT_IMP(a_no_accept_in_clear, state_r == S_CLEAR, in_stall && !out_valid_r)
  `ASSERT_IMP(a_cnt_bound, state_r == S_LOOK, cnt_r <= CNT_W'(DIM))
  `ASSERT_IMP(a_pend_after_issue, state_r == S_LOOK && pend_r, cnt_r != '0)
  `ASSERT_NEXT(a_elem_done, elem_go, state_r == S_IDLE && out_valid_r && out_last_r)

endmodule

// ----- rtl/elgt_ram.sv -----
module elgt_ram #(
  parameter int DW = elgt_pkg::RES_W,
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
